// ===== sv/wasa_pkg.sv =====
// ----------------------------------------------------------------------------
// wasa_pkg
// Shared constants for the window average speed alarm: field widths, the
// register map and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package wasa_pkg;

  localparam int unsigned WINDOW_DEF = 50;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned THR_W    = 14;
  localparam int unsigned PERS_W   = 4;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned RUN_W    = 4;
  localparam int unsigned CFG_W    = THR_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

  localparam logic [THR_W-1:0]  THR_RESET  = 14'd55;
  localparam logic [PERS_W-1:0] PERS_RESET = 4'd3;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST_WINDOWS = 1'd1;

  // level codes
  localparam logic [LEVEL_W-1:0] LVL_BELOW = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_OVER  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_MID   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_HIGH  = 2'd3;

endpackage

// ===== sv/window_average_speed_alarm_unit.sv =====
// ----------------------------------------------------------------------------
// window_average_speed_alarm_unit
// Sums WINDOW signed samples, divides by WINDOW (toward zero) through a
// reciprocal multiply and grades the average against a threshold, driving a
// persistence count and three indicator states.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle. Ready drops only when a window closes
//   while the finished-sum register is still blocked by a full output.
// Path: the edge that takes the window's last sample loads the finished-sum
//   register; the result then passes the multiply and output registers.
// Reset: sum and sample count cleared, run count 0, red and blue off, green
//   on, speed_threshold 55, persist_windows 3, no result pending.
module window_average_speed_alarm_unit #(
  parameter int unsigned WINDOW = wasa_pkg::WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [wasa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wasa_pkg::CFG_W-1:0]           cfg_wdata_i,
  // sample channel
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  input  logic signed [wasa_pkg::SAMPLE_W-1:0] sample_i,
  // result channel
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic signed [wasa_pkg::SAMPLE_W-1:0] average_o,
  output logic [wasa_pkg::LEVEL_W-1:0]         level_o,
  output logic                                 alarm_o,
  output logic                                 red_led_o,
  output logic                                 green_led_o,
  output logic                                 blue_led_o
);

  localparam int unsigned SW     = wasa_pkg::SAMPLE_W;
  localparam int unsigned CntW   = $clog2(WINDOW);
  localparam int unsigned SumW   = SW + CntW;
  // floor(n * Recip / 2^Shift) == floor(n / WINDOW) for every n < 2^SumW
  localparam int unsigned Shift  = SumW + CntW;
  localparam int unsigned RecipW = SumW + 2;
  localparam logic [63:0] RecipWide =
      ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RecipW-1:0] Recip = RecipWide[RecipW-1:0];
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam int unsigned QuotW  = SW + 1;
  localparam int unsigned CmpW   = SW + 2;
  localparam logic [CntW-1:0] CntLast = CntW'(WINDOW - 1);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [wasa_pkg::THR_W-1:0]  thr_q;
  logic [wasa_pkg::PERS_W-1:0] pers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= wasa_pkg::THR_RESET;
      pers_q <= wasa_pkg::PERS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wasa_pkg::REG_SPEED_THRESHOLD: thr_q  <= cfg_wdata_i;
        wasa_pkg::REG_PERSIST_WINDOWS: pers_q <= cfg_wdata_i[wasa_pkg::PERS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  logic out_vld_q, b_vld_q, a_vld_q;
  logic out_free, b_free, a_free;
  logic b_adv, a_adv;
  logic [CntW-1:0] cnt_q;
  logic in_xfer, win_done;

  assign out_free = !out_vld_q || result_ready_i;
  assign b_adv    = b_vld_q && out_free;
  assign b_free   = !b_vld_q || out_free;
  assign a_adv    = a_vld_q && b_free;
  assign a_free   = !a_vld_q || b_free;

  assign sample_ready_o = a_free || (cnt_q != CntLast);
  assign in_xfer        = sample_valid_i && sample_ready_o;
  assign win_done       = in_xfer && (cnt_q == CntLast);

  // --------------------------------------------------------------------------
  // accumulate
  // --------------------------------------------------------------------------
  logic signed [SumW-1:0] sum_q, sum_d;

  assign sum_d = sum_q + SumW'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (in_xfer) begin
      if (win_done) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // finished window sum
  logic signed [SumW-1:0] a_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (win_done) begin
      a_vld_q <= 1'b1;
    end else if (a_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_done) begin
      a_sum_q <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // magnitude times reciprocal
  // --------------------------------------------------------------------------
  logic [SumW-1:0]  a_abs;
  logic [ProdW-1:0] prod_d;
  logic [ProdW-1:0] b_prod_q;
  logic             b_neg_q;

  assign a_abs  = a_sum_q[SumW-1] ? SumW'(-a_sum_q) : SumW'(a_sum_q);
  assign prod_d = ProdW'(a_abs) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_free) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_prod_q <= prod_d;
      b_neg_q  <= a_sum_q[SumW-1];
    end
  end

  // --------------------------------------------------------------------------
  // grade, run count, indicators
  // --------------------------------------------------------------------------
  logic [QuotW-1:0]              quot;
  logic [QuotW-1:0]              avg_full;
  logic signed [SW-1:0]          avg_d;
  logic signed [CmpW-1:0]        avg_x, avg2_x, thr_x, thr2_x, thr3_x;
  logic [wasa_pkg::LEVEL_W-1:0]  level_d;
  logic [wasa_pkg::RUN_W-1:0]    run_q, run_d;
  logic                          alarm_d;
  logic                          red_q, green_q, blue_q;
  logic                          red_d, green_d, blue_d;
  logic signed [SW-1:0]          avg_q;
  logic [wasa_pkg::LEVEL_W-1:0]  level_q;
  logic                          alarm_q;

  assign quot     = b_prod_q[Shift +: QuotW];
  assign avg_full = b_neg_q ? (~quot + 1'b1) : quot;
  assign avg_d    = avg_full[SW-1:0];

  assign avg_x  = CmpW'(avg_d);
  assign avg2_x = avg_x <<< 1;
  assign thr_x  = $signed(CmpW'(thr_q));
  assign thr2_x = thr_x <<< 1;
  assign thr3_x = thr_x + thr2_x;

  always_comb begin
    if (avg_x >= thr2_x) begin
      level_d = wasa_pkg::LVL_HIGH;
    end else if (avg2_x >= thr3_x) begin
      level_d = wasa_pkg::LVL_MID;
    end else if (avg_x >= thr_x) begin
      level_d = wasa_pkg::LVL_OVER;
    end else begin
      level_d = wasa_pkg::LVL_BELOW;
    end
  end

  always_comb begin
    if (level_d == wasa_pkg::LVL_BELOW) begin
      run_d = '0;
    end else if (run_q == wasa_pkg::RUN_MAX) begin
      run_d = run_q;
    end else begin
      run_d = run_q + 1'b1;
    end
  end

  assign alarm_d = (run_d > pers_q);

  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    if (alarm_d) begin
      case (level_d)
        wasa_pkg::LVL_HIGH: begin
          green_d = 1'b0;
          red_d   = ~red_q;
        end
        wasa_pkg::LVL_MID: begin
          green_d = 1'b0;
          blue_d  = ~blue_q;
        end
        default: begin
          green_d = ~green_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      run_q     <= '0;
      red_q     <= 1'b0;
      green_q   <= 1'b1;
      blue_q    <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= b_vld_q;
      end
      if (b_adv) begin
        run_q   <= run_d;
        red_q   <= red_d;
        green_q <= green_d;
        blue_q  <= blue_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      avg_q   <= avg_d;
      level_q <= level_d;
      alarm_q <= alarm_d;
    end
  end

  // indicator registers change only when a new result is loaded
  assign result_valid_o = out_vld_q;
  assign average_o      = avg_q;
  assign level_o        = level_q;
  assign alarm_o        = alarm_q;
  assign red_led_o      = red_q;
  assign green_led_o    = green_q;
  assign blue_led_o     = blue_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_ready_low_only_on_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_ready_o |-> (a_vld_q && !b_free && cnt_q == CntLast))
    else $error("sample ready low without a blocked window");

  a_window_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_done |=> (a_vld_q && cnt_q == '0 && sum_q == '0))
    else $error("window close did not hand off and restart the sum");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> out_vld_q)
    else $error("multiply stage advanced without loading a result");

  a_below_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && level_q == wasa_pkg::LVL_BELOW) |-> (run_q == '0 && !alarm_q))
    else $error("below-threshold result with a live run count");

  a_alarm_needs_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && alarm_q) |-> (run_q != '0))
    else $error("alarm raised with an empty run count");

endmodule
